@@ src/lzwd_pkg.sv @@
// Shared types and constants for the LZW decoder.
package lzwd_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_MAX_CODE_BITS = 2'd0;
  localparam logic [1:0] CFG_PACKED_INPUT  = 2'd1;

  // Result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_INVALID   = 2'd1;
  localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

  // Fixed code properties
  localparam int ROOT_COUNT = 256;
  localparam logic [4:0] MIN_WIDTH = 5'd9;
  localparam logic [4:0] RESET_MAX_BITS = 5'd12;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;     // input transaction this cycle
    logic decode;     // classify the code, start dictionary read
    logic len_load;   // string length available
    logic walk;       // one prefix chain step
    logic fin;        // add entry, update history
    logic emit_fire;  // output transaction this cycle
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic code_ready;  // accepted input completes a code
    logic invalid;     // code in decode is invalid
    logic walk_done;   // chain walk reached its root
    logic emit_done;   // final byte of the string taken
  } stat_t;

endpackage

@@ src/lzwd_ram.sv @@
// Generic simple dual-port RAM with registered read.
module lzwd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/lzwd_ctrl.sv @@
// Controller state machine for the LZW decoder.
module lzwd_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  output logic           m_tvalid,
  input  logic           m_tready,
  input  lzwd_pkg::stat_t stat,
  output lzwd_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_LEN    = 3'd2;
  localparam logic [2:0] S_WALK   = 3'd3;
  localparam logic [2:0] S_FIN    = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_EMIT);

  // Commands decoded from state
  always_comb begin
    cmd.accept    = s_tvalid && (state == S_IDLE);
    cmd.decode    = (state == S_DECODE);
    cmd.len_load  = (state == S_LEN);
    cmd.walk      = (state == S_WALK);
    cmd.fin       = (state == S_FIN);
    cmd.emit_fire = m_tready && (state == S_EMIT);
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.accept && stat.code_ready) state_next = S_DECODE;
      end
      S_DECODE: begin
        state_next = stat.invalid ? S_EMIT : S_LEN;
      end
      S_LEN: begin
        state_next = S_WALK;
      end
      S_WALK: begin
        if (stat.walk_done) state_next = S_FIN;
      end
      S_FIN: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.emit_done) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ src/lzwd_datapath.sv @@
// Datapath: bit unpacking, dictionary, chain walk, string stack and output.
module lzwd_datapath #(
  parameter int DICT_BITS  = 12,
  parameter int MAX_STRING = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [4:0]      cfg_data,
  input  logic [15:0]     s_tdata,
  output logic [7:0]      m_tdata,
  output logic            m_tlast,
  output logic [1:0]      m_tuser,
  input  lzwd_pkg::cmd_t  cmd,
  output lzwd_pkg::stat_t stat
);

  localparam int AW = DICT_BITS;
  localparam int DEPTH = 1 << DICT_BITS;
  localparam int SW = $clog2(MAX_STRING);
  localparam int NW = $clog2(MAX_STRING + 1);

  // Configuration
  logic [4:0] max_code_bits;
  logic       packed_input;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_code_bits <= lzwd_pkg::RESET_MAX_BITS;
      packed_input  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        lzwd_pkg::CFG_MAX_CODE_BITS: max_code_bits <= cfg_data;
        lzwd_pkg::CFG_PACKED_INPUT:  packed_input  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Effective maximum width and table size
  logic [4:0]  eff;
  logic [16:0] size;
  always_comb begin
    eff = max_code_bits;
    if (eff < lzwd_pkg::MIN_WIDTH) eff = lzwd_pkg::MIN_WIDTH;
    if (eff > 5'(DICT_BITS)) eff = 5'(DICT_BITS);
    size = 17'd1 << eff;
  end

  // State registers
  logic [23:0]   acc;
  logic [4:0]    held;
  logic [4:0]    cur_width;
  logic [15:0]   code;
  logic [16:0]   entry_count;
  logic [AW-1:0] prev_code;
  logic          prev_valid;
  logic [15:0]   prev_len;
  logic [AW-1:0] base;
  logic          extra;
  logic [AW-1:0] t;
  logic [15:0]   p;
  logic [15:0]   lb;
  logic [16:0]   total;
  logic [NW-1:0] n;
  logic [NW-1:0] k;
  logic          over;
  logic          inv;
  logic [7:0]    first;

  // RAM ports
  logic [AW-1:0] dict_addr;
  logic          dict_we;
  logic [AW-1:0] pre_rd;
  logic [7:0]    chr_rd;
  logic [15:0]   len_rd;
  logic [15:0]   new_len;
  logic          stk_we;
  logic [SW-1:0] stk_waddr;
  logic [7:0]    stk_wdata;
  logic [SW-1:0] stk_raddr;
  logic [7:0]    stk_rd;

  // Input unpacking
  logic [23:0] acc_in;
  logic [4:0]  bits_in;
  logic [4:0]  bits_left;
  logic [15:0] code_shift;
  logic        have_code;
  always_comb begin
    acc_in     = {acc[15:0], s_tdata[7:0]};
    bits_in    = held + 5'd8;
    have_code  = (bits_in >= cur_width);
    bits_left  = bits_in - cur_width;
    code_shift = 16'((acc_in >> bits_left) & ((24'd1 << cur_width) - 24'd1));
  end

  // Code classification
  logic [16:0]   code_ext;
  logic          is_known;
  logic          is_kwkwk;
  logic [AW-1:0] base_next;
  always_comb begin
    code_ext  = {1'b0, code};
    is_known  = (code_ext < entry_count);
    is_kwkwk  = (code_ext == entry_count) && prev_valid && (entry_count < size);
    base_next = is_kwkwk ? prev_code : code[AW-1:0];
  end

  // Length with root handling
  logic [15:0] lb_now;
  logic [16:0] total_now;
  assign lb_now    = (base[AW-1:8] == '0) ? 16'd1 : len_rd;
  assign total_now = {1'b0, lb_now} + {16'd0, extra};

  // Walk step
  logic [7:0]  chr_now;
  logic [15:0] pn;
  assign chr_now = (t[AW-1:8] == '0) ? t[7:0] : chr_rd;
  assign pn      = p - 16'd1;

  // Entry add and width growth
  logic        add_ok;
  logic [16:0] ec_after;
  logic [17:0] grow_lim;
  logic        grow_fin;
  logic        grow_inv;
  always_comb begin
    add_ok   = prev_valid && (entry_count < size);
    ec_after = add_ok ? entry_count + 17'd1 : entry_count;
    grow_lim = 18'd1 << cur_width;
    grow_fin = packed_input && (cur_width < eff) && ({1'b0, ec_after} + 18'd1 >= grow_lim);
    grow_inv = packed_input && (cur_width < eff)
               && ({1'b0, entry_count} + 18'd1 >= grow_lim);
    new_len  = (prev_len == 16'hFFFF) ? 16'hFFFF : prev_len + 16'd1;
  end

  // Dictionary address selection
  always_comb begin
    dict_addr = t;
    dict_we   = 1'b0;
    if (cmd.decode) begin
      dict_addr = base_next;
    end else if (cmd.len_load) begin
      dict_addr = base;
    end else if (cmd.walk) begin
      dict_addr = pre_rd;
    end else if (cmd.fin) begin
      dict_addr = entry_count[AW-1:0];
      dict_we   = add_ok;
    end
  end

  // String stack ports
  always_comb begin
    stk_we    = 1'b0;
    stk_waddr = pn[SW-1:0];
    stk_wdata = chr_now;
    stk_raddr = k[SW-1:0];
    if (cmd.walk) begin
      stk_we = (p != 16'd0) && ({1'b0, pn} < 17'(n));
    end else if (cmd.fin) begin
      stk_we    = extra && ({1'b0, lb} < 17'(n));
      stk_waddr = lb[SW-1:0];
      stk_wdata = first;
      stk_raddr = '0;
    end else if (cmd.emit_fire) begin
      stk_raddr = SW'(k + NW'(1));
    end
  end

  lzwd_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_prefix_ram (
    .clk(clk), .we(dict_we), .waddr(dict_addr), .wdata(prev_code),
    .raddr(dict_addr), .rdata(pre_rd)
  );

  lzwd_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_char_ram (
    .clk(clk), .we(dict_we), .waddr(dict_addr), .wdata(first),
    .raddr(dict_addr), .rdata(chr_rd)
  );

  lzwd_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_length_ram (
    .clk(clk), .we(dict_we), .waddr(dict_addr), .wdata(new_len),
    .raddr(dict_addr), .rdata(len_rd)
  );

  lzwd_ram #(.WIDTH(8), .DEPTH(MAX_STRING)) u_stack_ram (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rd)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      acc         <= '0;
      held        <= '0;
      cur_width   <= lzwd_pkg::MIN_WIDTH;
      entry_count <= 17'(lzwd_pkg::ROOT_COUNT);
      prev_valid  <= 1'b0;
      k           <= '0;
      inv         <= 1'b0;
    end else begin
      if (cmd.accept && packed_input) begin
        if (have_code) begin
          held <= bits_left;
          acc  <= acc_in & ((24'd1 << bits_left) - 24'd1);
        end else begin
          held <= bits_in;
          acc  <= acc_in;
        end
      end
      if (cmd.decode) begin
        k   <= '0;
        inv <= !is_known && !is_kwkwk;
        if (!is_known && !is_kwkwk && grow_inv) cur_width <= cur_width + 5'd1;
      end
      if (cmd.fin) begin
        entry_count <= ec_after;
        prev_valid  <= 1'b1;
        if (grow_fin) cur_width <= cur_width + 5'd1;
      end
      if (cmd.emit_fire) k <= k + NW'(1);
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      code <= packed_input ? code_shift : s_tdata;
    end
    if (cmd.decode) begin
      base  <= base_next;
      extra <= is_kwkwk;
      n     <= NW'(1);
      over  <= 1'b0;
    end
    if (cmd.len_load) begin
      lb    <= lb_now;
      p     <= lb_now;
      t     <= base;
      total <= total_now;
      n     <= (total_now < 17'(MAX_STRING)) ? NW'(total_now) : NW'(MAX_STRING);
      over  <= (total_now > 17'(MAX_STRING));
    end
    if (cmd.walk) begin
      if (p != 16'd0) p <= pn;
      if ((p == 16'd0) || (pn == 16'd0)) begin
        first <= chr_now;
      end else begin
        t <= pre_rd;
      end
    end
    if (cmd.fin) begin
      prev_code <= code[AW-1:0];
      prev_len  <= extra ? (total[16] ? 16'hFFFF : total[15:0]) : lb;
    end
  end

  // Status to controller
  always_comb begin
    stat.code_ready = !packed_input || have_code;
    stat.invalid    = !is_known && !is_kwkwk;
    stat.walk_done  = (p == 16'd0) || (pn == 16'd0);
    stat.emit_done  = cmd.emit_fire && (k + NW'(1) == n);
  end

  // Output fields
  assign m_tdata = inv ? 8'd0 : stk_rd;
  assign m_tlast = (k + NW'(1) == n);
  assign m_tuser = inv ? lzwd_pkg::STATUS_INVALID
                 : (over ? lzwd_pkg::STATUS_TRUNCATED : lzwd_pkg::STATUS_OK);

endmodule

@@ src/lzw_decoder.sv @@
// LZW decoder top level: controller and datapath.
// A code passes the decode, length, walk and finish states after the accepting edge before its
// first byte is offered; the walk makes one dictionary read per cycle over the stored length.
// An invalid code goes from decode to emit. No input is taken until a string's last byte is
// taken. An input that does not finish a packed code gives no result and the decoder stays idle.
// Reset (synchronous) clears control state; roots are decoded by logic, no clearing pass.
module lzw_decoder #(
  parameter int DICT_BITS  = 12,
  parameter int MAX_STRING = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // in_value[15:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // out_byte[7:0]
  output logic        m_tlast,
  output logic [1:0]  m_tuser    // status[1:0]
);

  lzwd_pkg::cmd_t  cmd;
  lzwd_pkg::stat_t stat;

  lzwd_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready),
    .stat(stat), .cmd(cmd)
  );

  lzwd_datapath #(.DICT_BITS(DICT_BITS), .MAX_STRING(MAX_STRING)) u_datapath (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tdata(s_tdata),
    .m_tdata(m_tdata), .m_tlast(m_tlast), .m_tuser(m_tuser),
    .cmd(cmd), .stat(stat)
  );

endmodule

@@ sim/lzw_decoder_test.sv @@
// Self-checking stream testbench for the LZW decoder with a local dictionary predictor.
module lzw_decoder_test;

  localparam int DICT_BITS  = 12;
  localparam int MAX_STRING = 64;
  localparam int DICT_SIZE  = 1 << DICT_BITS;
  localparam logic [1:0] CFG_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE = 80;
  localparam int HOLD_CYCLES = 600;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [1:0] status;
  } byte_exp_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [4:0]  cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // in_value[15:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // out_byte[7:0]
  logic        m_tlast;
  logic [1:0]  m_tuser;   // status[1:0]

  lzw_decoder #(.DICT_BITS(DICT_BITS), .MAX_STRING(MAX_STRING)) i_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser)
  );

  // Pending input codes/bytes and expected output bytes
  logic [15:0] code_q[$];
  byte_exp_t   byte_q[$];
  int          errors = 0;
  int          send_idle = 0;
  int          recv_idle = 0;
  bit          hold_go = 0;

  // Shadow decoder state
  logic [16:0] dict_prefix[DICT_SIZE];
  logic [7:0]  dict_char[DICT_SIZE];
  logic [15:0] dict_len[DICT_SIZE];
  logic [7:0]  spell[MAX_STRING];
  int unsigned dict_count;
  int unsigned last_code;
  bit          last_valid;
  int unsigned bit_acc;
  int unsigned acc_bits;
  int unsigned code_width;
  int unsigned max_bits_reg;
  bit          packed_reg;

  // Clock
  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned eff_width();
    if (max_bits_reg < 9) return 9;
    if (max_bits_reg > DICT_BITS) return DICT_BITS;
    return max_bits_reg;
  endfunction

  function automatic int unsigned low_mask(input int unsigned n);
    return (n >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 1);
  endfunction

  // Decode one code: expected bytes go to byte_q, dictionary grows
  function automatic void decode_code(input int unsigned c);
    int unsigned size, base, lb, total, n, t, p, e;
    bit extra;
    logic [7:0] first;
    logic [1:0] st;
    byte_exp_t r;
    size = 1 << eff_width();
    if (c < dict_count) begin
      base = c;
      extra = 0;
    end else if (c == dict_count && last_valid && dict_count < size) begin
      base = last_code;
      extra = 1;
    end else begin
      r.data = 8'd0;
      r.last = 1'b1;
      r.status = lzwd_pkg::STATUS_INVALID;
      byte_q.push_back(r);
      return;
    end
    base = base % DICT_SIZE;
    lb = dict_len[base];
    total = lb + extra;
    n = (total < MAX_STRING) ? total : MAX_STRING;
    t = base;
    p = lb;
    while (p > 0) begin
      p--;
      if (p < n) spell[p] = dict_char[t];
      if (p == 0) break;
      t = dict_prefix[t] % DICT_SIZE;
    end
    first = dict_char[t];
    if (extra && lb < n) spell[lb] = first;
    st = (total > MAX_STRING) ? lzwd_pkg::STATUS_TRUNCATED : lzwd_pkg::STATUS_OK;
    for (int k = 0; k < n; k++) begin
      r.data = spell[k];
      r.last = (k + 1 == n);
      r.status = st;
      byte_q.push_back(r);
    end
    if (last_valid && dict_count < size) begin
      e = dict_count % DICT_SIZE;
      dict_prefix[e] = last_code;
      dict_char[e] = first;
      dict_len[e] = (dict_len[last_code % DICT_SIZE] == 16'hFFFF) ? 16'hFFFF :
                    dict_len[last_code % DICT_SIZE] + 16'd1;
      dict_count++;
    end
    last_code = c;
    last_valid = 1;
  endfunction

  // Queue one input transaction and predict its output
  function automatic void push_input(input logic [15:0] v);
    int unsigned code;
    code_q.push_back(v);
    if (!packed_reg) begin
      decode_code(v);
      return;
    end
    bit_acc = ((bit_acc << 8) | v[7:0]) & 32'hFF_FFFF;
    acc_bits += 8;
    if (acc_bits < code_width) return;
    acc_bits -= code_width;
    code = (bit_acc >> acc_bits) & low_mask(code_width);
    bit_acc &= low_mask(acc_bits);
    decode_code(code);
    if (code_width < eff_width() && dict_count + 1 >= (1 << code_width)) code_width++;
  endfunction

  // Code choice biased toward recent entries and the not-yet-defined case
  function automatic int unsigned pick_code(input int unsigned cnt);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 25) return cnt;
    if (r < 45) return cnt - 1;
    if (r < 52) return $urandom_range(65535, cnt + 1);
    if (r < 62) return $urandom_range(255);
    return $urandom_range(cnt - 1);
  endfunction

  // Whole-code stream
  task automatic gen_codes(input int num);
    for (int i = 0; i < num; i++) push_input(pick_code(dict_count));
  endtask

  // Packed stream: codes assembled MSB first at the width the decoder will use
  task automatic gen_packed(input int num);
    int unsigned tcount, twidth, lead_n, lead_v, ub, un, w, c, nb, size;
    bit tvalid, ok;
    tcount = dict_count;
    twidth = code_width;
    tvalid = last_valid;
    lead_n = acc_bits;
    lead_v = bit_acc;
    ub = 0;
    un = 0;
    for (int i = 0; i < num; i++) begin
      w = twidth;
      c = pick_code(tcount) & low_mask(w);
      nb = w;
      if (lead_n > 0) begin
        // leftover bits from an earlier stream form the top of this code
        c = (lead_v << (w - lead_n)) | (c & low_mask(w - lead_n));
        nb = w - lead_n;
        lead_n = 0;
      end
      ub = (ub << nb) | (c & low_mask(nb));
      un += nb;
      while (un >= 8) begin
        push_input({8'($urandom), 8'((ub >> (un - 8)) & 8'hFF)});
        un -= 8;
        ub &= low_mask(un);
      end
      size = 1 << eff_width();
      ok = (c < tcount) || (c == tcount && tvalid && tcount < size);
      if (ok) begin
        if (tvalid && tcount < size) tcount++;
        tvalid = 1;
      end
      if (twidth < eff_width() && tcount + 1 >= (1 << twidth)) twidth++;
    end
    if (un > 0) push_input({8'($urandom), 8'((ub << (8 - un)) & 8'hFF)});
  endtask

  // Register write, only while idle
  task automatic cfg_write(input logic [1:0] idx, input logic [4:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == lzwd_pkg::CFG_MAX_CODE_BITS) max_bits_reg = val;
    else if (idx == lzwd_pkg::CFG_PACKED_INPUT) packed_reg = val[0];
  endtask

  // Wait until every input is taken and every expected byte has arrived
  task automatic drain();
    do @(negedge clk); while (code_q.size() != 0 || s_tvalid || byte_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
    $display("error: %s got %0h expected %0h", what, got, want);
    errors++;
  endtask

  // Input driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (code_q.size() != 0 && $urandom_range(99) >= send_idle) begin
        s_tdata <= code_q.pop_front();
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off so the decoder backs up into its input
  int  hold_cnt = 0;
  bit  hold_on = 0;
  always @(posedge clk) begin
    if (hold_go && hold_cnt < HOLD_CYCLES) begin
      hold_cnt <= hold_cnt + 1;
      hold_on <= 1'b1;
    end else begin
      hold_on <= 1'b0;
    end
  end

  // Output monitor and checker
  byte_exp_t want;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (byte_q.size() == 0) begin
          report("unexpected transaction, byte", m_tdata, 8'h00);
        end else begin
          want = byte_q.pop_front();
          if (m_tdata !== want.data) report("byte", m_tdata, want.data);
          if (m_tlast !== want.last) report("last", {7'd0, m_tlast}, {7'd0, want.last});
          if (m_tuser !== want.status) begin
            report("status", {6'd0, m_tuser}, {6'd0, want.status});
          end
        end
      end
      if (hold_on) begin
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // Timeout
  int cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("lzw_decoder: mismatch");
      $finish;
    end
  end

  // Stimulus sequence
  initial begin
    int guard;
    cfg_we = 0;
    cfg_index = lzwd_pkg::CFG_MAX_CODE_BITS;
    cfg_data = 0;
    s_tvalid = 0;
    s_tdata = 0;
    m_tready = 0;
    for (int i = 0; i < DICT_SIZE; i++) begin
      dict_prefix[i] = 0;
      dict_char[i] = (i < lzwd_pkg::ROOT_COUNT) ? 8'(i) : 8'd0;
      dict_len[i] = (i < lzwd_pkg::ROOT_COUNT) ? 16'd1 : 16'd0;
    end
    dict_count = lzwd_pkg::ROOT_COUNT;
    last_code = 0;
    last_valid = 0;
    bit_acc = 0;
    acc_bits = 0;
    code_width = lzwd_pkg::MIN_WIDTH;
    max_bits_reg = lzwd_pkg::RESET_MAX_BITS;
    packed_reg = 1;
    rst = 1;
    repeat (4) @(posedge clk);
    rst <= 0;

    // Directed: roots, chaining, undefined-code case, invalid codes, ignored index
    cfg_write(CFG_SPARE, 5'd31);
    cfg_write(lzwd_pkg::CFG_PACKED_INPUT, 5'd0);
    push_input(16'd300);
    push_input(16'd65);
    push_input(16'd66);
    push_input(16'd256);
    push_input(16'd259);
    push_input(16'd260);
    push_input(16'd0);
    push_input(16'd255);
    push_input(16'hFFFF);
    push_input(16'h8000);
    push_input(16'd262);
    push_input(16'd263);
    push_input(16'h7FFF);
    drain();

    // Whole codes, sender idling, width limit 12
    cfg_write(lzwd_pkg::CFG_MAX_CODE_BITS, 5'd12);
    send_idle = 75;
    gen_codes(10);
    drain();

    // Packed bytes, narrowest table, receiver stalling
    cfg_write(lzwd_pkg::CFG_PACKED_INPUT, 5'd1);
    cfg_write(lzwd_pkg::CFG_MAX_CODE_BITS, 5'd9);
    send_idle = 0;
    recv_idle = 75;
    gen_packed(16);
    drain();

    // Whole codes until the table is full, clamped low width, both idling;
    // a run of undefined-code cases first builds strings past the length bound
    cfg_write(lzwd_pkg::CFG_PACKED_INPUT, 5'd0);
    cfg_write(lzwd_pkg::CFG_MAX_CODE_BITS, 5'd0);
    send_idle = 24;
    recv_idle = 24;
    guard = 0;
    while (dict_count < 512 && guard < 400) begin
      if (guard < 80) push_input(16'(dict_count));
      else push_input(16'($urandom_range(dict_count)));
      guard++;
    end
    gen_codes(4);
    drain();

    // Packed bytes, clamped high width, no idling, long hold-off
    cfg_write(lzwd_pkg::CFG_PACKED_INPUT, 5'd1);
    cfg_write(lzwd_pkg::CFG_MAX_CODE_BITS, 5'd31);
    send_idle = 0;
    recv_idle = 0;
    gen_packed(12);
    hold_go = 1;
    drain();

    if (errors == 0) begin
      $display("lzw_decoder: match");
    end else begin
      $display("lzw_decoder: mismatch");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/lzwd_pkg.sv
src/lzwd_ram.sv
src/lzwd_ctrl.sv
src/lzwd_datapath.sv
src/lzw_decoder.sv
sim/lzw_decoder_test.sv
